FILE: src/assert_macros.svh
// Assertion helpers for the checker file wsd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define ASSERT_IMPLY(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while dis is high.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: src/wsd_pkg.sv
package wsd_pkg;

  // Parser phase of the frame header / payload walk.
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  // One classified item on its way from the parser to the output stage.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
    logic       empty;
  } cmd_t;

  localparam int unsigned MASK_BIT  = 7;
  localparam logic [6:0]  LEN_EXT16 = 7'd126;
  localparam logic [6:0]  LEN_EXT64 = 7'd127;
  localparam logic [2:0]  EXT16_CNT = 3'd1;
  localparam logic [2:0]  EXT64_CNT = 3'd7;
  localparam logic [2:0]  KEY_CNT   = 3'd3;

endpackage

FILE: src/websocket_frame_deframer_unit.sv
// WebSocket frame deframer.
// Input channel: one raw link byte per item on in_byte; an item is taken at a
// rising edge with push high and full low. Frames follow each other directly.
// Output channel: one result per payload byte (payload_byte unmasked, with
// frame_last on the final byte) and one result with frame_empty and
// frame_last set, payload_byte zero, for a frame with no payload. The oldest
// result sits on the ports while empty is low and leaves on pop.
// Header bytes (first byte, length, extended length, mask key) produce no
// result. Throughput: one item per cycle in both directions while full is
// low and the receiver pops. Each result passes the queue, then the output
// register. A parser classifies each byte, a DEPTH-entry queue decouples it
// from the output register, so DEPTH+1 results can wait before full rises.
// Reset (rst, synchronous) returns the parser to the first header byte and
// drops every waiting result. When the receiver stops popping, results pile
// up in the queue; full then holds off the sender without losing any byte.
module websocket_frame_deframer_unit
  import wsd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] payload_byte,
  output logic       frame_last,
  output logic       frame_empty
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t q_data;
  logic q_valid;
  logic q_pop;

  // Take an item whenever the queue has room; every byte adds at most one.
  assign accept = push && !full;

  // Front: walk the header, track length and key, classify each byte.
  wsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // Queue between parser and output stage.
  wsd_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_valid),
    .wr_data   (cmd),
    .rd_en     (q_pop),
    .rd_data   (q_data),
    .not_empty (q_valid),
    .full      (full)
  );

  // Back: apply the key byte and hold the result for the receiver.
  wsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .payload_byte (payload_byte),
    .frame_last   (frame_last),
    .frame_empty  (frame_empty)
  );

endmodule

FILE: src/wsd_fifo.sv
module wsd_fifo
  import wsd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic not_empty,
  output logic full
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign rd_data   = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CntW'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/wsd_front.sv
module wsd_front
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  phase_t      phase, phase_next;
  logic [63:0] rem_len, rem_len_next;
  logic [2:0]  hdr_cnt, hdr_cnt_next;
  logic [31:0] mask_key, mask_key_next;
  logic        mask_present, mask_present_next;
  logic [1:0]  pos, pos_next;

  logic [6:0]  len7;
  logic        len_ext;
  logic [63:0] rem_shift;
  logic [7:0]  key_byte;

  assign len7      = in_byte[6:0];
  assign len_ext   = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
  assign rem_shift = {rem_len[55:0], in_byte};

  // Key byte for the current payload position, first key byte at position 0.
  always_comb begin
    unique case (pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Next state.
  always_comb begin
    phase_next        = phase;
    rem_len_next      = rem_len;
    hdr_cnt_next      = hdr_cnt;
    mask_key_next     = mask_key;
    mask_present_next = mask_present;
    pos_next          = pos;
    if (accept) begin
      unique case (phase)
        PH_HDR0: begin
          phase_next = PH_HDR1;
        end
        PH_HDR1: begin
          mask_present_next = in_byte[MASK_BIT];
          mask_key_next     = '0;
          if (len_ext) begin
            rem_len_next = '0;
            hdr_cnt_next = (len7 == LEN_EXT16) ? EXT16_CNT : EXT64_CNT;
            phase_next   = PH_EXT;
          end else begin
            rem_len_next = {57'd0, len7};
            if (in_byte[MASK_BIT]) begin
              hdr_cnt_next = KEY_CNT;
              phase_next   = PH_KEY;
            end else begin
              pos_next   = '0;
              phase_next = (len7 == '0) ? PH_HDR0 : PH_DATA;
            end
          end
        end
        PH_EXT: begin
          rem_len_next = rem_shift;
          if (hdr_cnt == '0) begin
            if (mask_present) begin
              hdr_cnt_next = KEY_CNT;
              phase_next   = PH_KEY;
            end else begin
              pos_next   = '0;
              phase_next = (rem_shift == '0) ? PH_HDR0 : PH_DATA;
            end
          end else begin
            hdr_cnt_next = hdr_cnt - 1'b1;
          end
        end
        PH_KEY: begin
          mask_key_next = {mask_key[23:0], in_byte};
          if (hdr_cnt == '0) begin
            pos_next   = '0;
            phase_next = (rem_len == '0) ? PH_HDR0 : PH_DATA;
          end else begin
            hdr_cnt_next = hdr_cnt - 1'b1;
          end
        end
        PH_DATA: begin
          rem_len_next = rem_len - 1'b1;
          pos_next     = pos + 1'b1;
          if (rem_len == 64'd1) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
          phase_next = PH_HDR1;
        end
      endcase
    end
  end

  // Outputs: emit an item for every payload byte and for each empty frame.
  always_comb begin
    cmd_valid = 1'b0;
    cmd       = '0;
    if (accept) begin
      unique case (phase)
        PH_HDR1: begin
          if (!len_ext && !in_byte[MASK_BIT] && (len7 == '0)) begin
            cmd_valid = 1'b1;
            cmd.last  = 1'b1;
            cmd.empty = 1'b1;
          end
        end
        PH_EXT: begin
          if ((hdr_cnt == '0) && !mask_present && (rem_shift == '0)) begin
            cmd_valid = 1'b1;
            cmd.last  = 1'b1;
            cmd.empty = 1'b1;
          end
        end
        PH_KEY: begin
          if ((hdr_cnt == '0) && (rem_len == '0)) begin
            cmd_valid = 1'b1;
            cmd.last  = 1'b1;
            cmd.empty = 1'b1;
          end
        end
        PH_DATA: begin
          cmd_valid = 1'b1;
          cmd.data  = in_byte;
          cmd.key   = mask_present ? key_byte : 8'd0;
          cmd.last  = (rem_len == 64'd1);
          cmd.empty = 1'b0;
        end
        default: begin
          cmd_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      rem_len      <= '0;
      hdr_cnt      <= '0;
      mask_key     <= '0;
      mask_present <= 1'b0;
      pos          <= '0;
    end else begin
      phase        <= phase_next;
      rem_len      <= rem_len_next;
      hdr_cnt      <= hdr_cnt_next;
      mask_key     <= mask_key_next;
      mask_present <= mask_present_next;
      pos          <= pos_next;
    end
  end

endmodule

FILE: src/wsd_back.sv
module wsd_back
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_data,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] payload_byte,
  output logic       frame_last,
  output logic       frame_empty
);

  logic out_valid;

  // Refill the output register when it is free or being drained.
  assign q_pop = q_valid && (!out_valid || pop);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      payload_byte <= q_data.data ^ q_data.key;
      frame_last   <= q_data.last;
      frame_empty  <= q_data.empty;
    end
  end

endmodule

FILE: src/wsd_checker.sv
`include "assert_macros.svh"

module wsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] payload_byte,
  input logic       frame_last,
  input logic       frame_empty
);

  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, empty)
  `ASSERT_IMPLY(a_empty_frame_form, clk, rst, !empty && frame_empty,
                frame_last && (payload_byte == 8'd0))
  `ASSERT_NEXT(a_no_spurious, clk, rst,
               empty && !(push && !full) && !$past(push && !full), empty)
  `ASSERT_NEXT(a_stall_hold, clk, rst, !empty && !pop,
               !empty && $stable(payload_byte) && $stable(frame_last) && $stable(frame_empty))

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (
  .clk          (clk),
  .rst          (rst),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .payload_byte (payload_byte),
  .frame_last   (frame_last),
  .frame_empty  (frame_empty)
);
